[hw/rtl/accumulator_cpu_execute_top_macros.svh]
// ----------------------------------------------------------------------------
// Accumulator execute assertion macros
// Shared concurrent assertion forms, clocked on clock and gated by reset.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_CPU_EXECUTE_TOP_MACROS_SVH

// Same-cycle implication
`define ACE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define ACE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ace_pkg.sv]
// ----------------------------------------------------------------------------
// Accumulator execute package
// Widths, operation and fault codes, shared unit kinds and control structs.
// ----------------------------------------------------------------------------
package ace_pkg;

   localparam int ACC_W         = 8;
   localparam int MODE_W        = 5;
   localparam int OPND_W        = 8;
   localparam int FAULT_W       = 2;
   localparam int CNT_W         = $clog2(ACC_W);
   localparam int MEM_DEPTH_DEF = 256;

   // Operation numbers
   localparam logic [MODE_W-1:0] OP_LDM  = 5'd0;
   localparam logic [MODE_W-1:0] OP_LDI  = 5'd1;
   localparam logic [MODE_W-1:0] OP_STO  = 5'd2;
   localparam logic [MODE_W-1:0] OP_ADD  = 5'd3;
   localparam logic [MODE_W-1:0] OP_SUB  = 5'd4;
   localparam logic [MODE_W-1:0] OP_MUL  = 5'd5;
   localparam logic [MODE_W-1:0] OP_DIV  = 5'd6;
   localparam logic [MODE_W-1:0] OP_INC  = 5'd7;
   localparam logic [MODE_W-1:0] OP_DEC  = 5'd8;
   localparam logic [MODE_W-1:0] OP_AND  = 5'd9;
   localparam logic [MODE_W-1:0] OP_OR   = 5'd10;
   localparam logic [MODE_W-1:0] OP_NOT  = 5'd11;
   localparam logic [MODE_W-1:0] OP_JMP  = 5'd12;
   localparam logic [MODE_W-1:0] OP_JZ   = 5'd13;
   localparam logic [MODE_W-1:0] OP_JNZ  = 5'd14;
   localparam logic [MODE_W-1:0] OP_JG   = 5'd15;
   localparam logic [MODE_W-1:0] OP_JL   = 5'd16;
   localparam logic [MODE_W-1:0] OP_JGE  = 5'd17;
   localparam logic [MODE_W-1:0] OP_JLE  = 5'd18;
   localparam logic [MODE_W-1:0] OP_HALT = 5'd19;

   // Fault codes
   localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_UNKNOWN = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_DIV0    = 2'd2;

   // Shared unit operation kinds
   localparam logic [2:0] UK_ADD = 3'd0;
   localparam logic [2:0] UK_SUB = 3'd1;
   localparam logic [2:0] UK_MUL = 3'd2;
   localparam logic [2:0] UK_DIV = 3'd3;
   localparam logic [2:0] UK_AND = 3'd4;
   localparam logic [2:0] UK_OR  = 3'd5;
   localparam logic [2:0] UK_NOT = 3'd6;

   typedef struct packed {
      logic       start;
      logic [2:0] kind;
   } ace_unit_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ace_unit_sts_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ace_mem_ctl_type;

endpackage

[hw/rtl/accumulator_cpu_execute_top.sv]
// ----------------------------------------------------------------------------
// Accumulator execute top level
// Runs one accumulator-machine instruction per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction (operation number and operand); rsp_*
//   returns the next instruction index, the accumulator, the halted flag
//   and the latched fault code, one response per request.
//   An instruction is accepted, its data address is reduced modulo
//   MEM_DEPTH and the read issued, and it executes on the read data;
//   simple operations then go straight on, add/sub/inc/dec/logic pass
//   through the shared unit, and multiply and divide iterate in it.
//   Last, the response register is loaded. The serial multiply and
//   divide in the shared unit set the worst case. Once halted, a
//   request goes straight to loading the response register.
//   req_tready is high only while no instruction is in progress; a new
//   request may be taken while the previous response still waits.
//   A stalled response holds; the next one waits in the sequencer.
//   Reset (synchronous) clears accumulator, index, halt state, fault and
//   the memory valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "accumulator_cpu_execute_top_macros.svh"

module accumulator_cpu_execute_top
   import ace_pkg::*;
#(
   parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [4:0] mode, [12:5] operand, [15:13] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] next_index, [15:8] accumulator,
                                    // [16] halted, [18:17] fault, [23:19] zero
);

   localparam int AW = $clog2(MEM_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADDR = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [OPND_W-1:0]  opnd_ff, opnd_in;
   logic [OPND_W-1:0]  addr_ff, addr_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [OPND_W-1:0]  index_ff, index_in;
   logic               stopped_ff, stopped_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;

   ace_mem_ctl_type    mem_ctl;
   logic [ACC_W-1:0]   mem_rd_data;
   ace_unit_req_type   unit_req;
   ace_unit_sts_type   unit_sts;
   logic [ACC_W-1:0]   unit_b;
   logic [ACC_W-1:0]   unit_result;
   logic               take;
   logic               neg;
   logic               addr_over;

   ace_data_mem #(
      .DEPTH (MEM_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .addr    (addr_ff[AW-1:0]),
      .wr_data (acc_ff),
      .rd_data (mem_rd_data)
   );

   ace_iter_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .req    (unit_req),
      .op_a   (acc_ff),
      .op_b   (unit_b),
      .sts    (unit_sts),
      .result (unit_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign neg        = acc_ff[ACC_W-1];
   assign addr_over  = {1'b0, addr_ff} >= 9'(MEM_DEPTH);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      opnd_in       = opnd_ff;
      addr_in       = addr_ff;
      acc_in        = acc_ff;
      index_in      = index_ff;
      stopped_in    = stopped_ff;
      fault_in      = fault_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_ctl       = '0;
      unit_req      = '0;
      unit_b        = mem_rd_data;
      take          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tdata[4:0];
               opnd_in  = req_tdata[12:5];
               addr_in  = req_tdata[12:5];
               state_in = stopped_ff ? ST_DONE : ST_ADDR;
            end
         end
         ST_ADDR: begin
            // Reduce the address modulo the depth, then read
            if (addr_over) begin
               addr_in = addr_ff - OPND_W'(MEM_DEPTH);
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            index_in = index_ff + 1'b1;
            state_in = ST_DONE;
            unique case (mode_ff)
               OP_LDM: acc_in = mem_rd_data;
               OP_LDI: acc_in = opnd_ff;
               OP_STO: mem_ctl.wr_en = 1'b1;
               OP_ADD: begin
                  unit_req = '{start: 1'b1, kind: UK_ADD};
                  state_in = ST_WAIT;
               end
               OP_SUB: begin
                  unit_req = '{start: 1'b1, kind: UK_SUB};
                  state_in = ST_WAIT;
               end
               OP_MUL: begin
                  unit_req = '{start: 1'b1, kind: UK_MUL};
                  state_in = ST_WAIT;
               end
               OP_DIV: begin
                  if (mem_rd_data == '0) begin
                     stopped_in = 1'b1;
                     fault_in   = FAULT_DIV0;
                  end else begin
                     unit_req = '{start: 1'b1, kind: UK_DIV};
                     state_in = ST_WAIT;
                  end
               end
               OP_INC: begin
                  unit_b   = ACC_W'(1);
                  unit_req = '{start: 1'b1, kind: UK_ADD};
                  state_in = ST_WAIT;
               end
               OP_DEC: begin
                  unit_b   = ACC_W'(1);
                  unit_req = '{start: 1'b1, kind: UK_SUB};
                  state_in = ST_WAIT;
               end
               OP_AND: begin
                  unit_req = '{start: 1'b1, kind: UK_AND};
                  state_in = ST_WAIT;
               end
               OP_OR: begin
                  unit_req = '{start: 1'b1, kind: UK_OR};
                  state_in = ST_WAIT;
               end
               OP_NOT: begin
                  unit_req = '{start: 1'b1, kind: UK_NOT};
                  state_in = ST_WAIT;
               end
               OP_JMP:  take = 1'b1;
               OP_JZ:   take = (acc_ff == '0);
               OP_JNZ:  take = (acc_ff != '0);
               OP_JG:   take = !neg && (acc_ff != '0);
               OP_JL:   take = neg;
               OP_JGE:  take = !neg;
               OP_JLE:  take = neg || (acc_ff == '0);
               OP_HALT: stopped_in = 1'b1;
               default: begin
                  stopped_in = 1'b1;
                  fault_in   = FAULT_UNKNOWN;
               end
            endcase
            if (take) begin
               index_in = {1'b0, opnd_ff[OPND_W-1:1]};
            end
         end
         ST_WAIT: begin
            // Hold until the shared unit finishes
            if (unit_sts.done) begin
               acc_in   = unit_result;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the response register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, fault_ff, stopped_ff, acc_ff, index_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         index_ff     <= '0;
         stopped_ff   <= 1'b0;
         fault_ff     <= FAULT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         index_ff     <= index_in;
         stopped_ff   <= stopped_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      opnd_ff     <= opnd_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `ACE_ASSERT_NEXT(a_stop_sticks, stopped_ff, stopped_ff, "halt state cleared without reset")
   `ACE_ASSERT_NOW(a_fault_stops, fault_ff != FAULT_NONE, stopped_ff, "fault latched while running")
   `ACE_ASSERT_NOW(a_unit_in_wait, unit_sts.busy || unit_sts.done, state_ff == ST_WAIT, "shared unit active outside wait")
   `ACE_ASSERT_NOW(a_read_in_range, mem_ctl.rd_en, !addr_over, "memory read with unreduced address")

endmodule

[hw/rtl/ace_data_mem.sv]
// ----------------------------------------------------------------------------
// Accumulator execute data memory
// Single-port byte store with registered read and per-entry valid bits;
// an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module ace_data_mem
   import ace_pkg::*;
#(
   parameter int DEPTH = MEM_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  ace_mem_ctl_type     ctl,
   input  logic [AW-1:0]       addr,
   input  logic [ACC_W-1:0]    wr_data,
   output logic [ACC_W-1:0]    rd_data
);

   logic [ACC_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [ACC_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // Mark written entries
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // Write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         rd_valid_ff <= valid_ff[addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[hw/rtl/ace_iter_unit.sv]
// ----------------------------------------------------------------------------
// Accumulator execute shared arithmetic unit
// Logic and add/sub computed at the request and registered; multiply by shift-add and divide by
// restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module ace_iter_unit
   import ace_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ace_unit_req_type  req,
   input  logic [ACC_W-1:0]  op_a,
   input  logic [ACC_W-1:0]  op_b,
   output ace_unit_sts_type  sts,
   output logic [ACC_W-1:0]  result
);

   logic [2:0]       kind_ff, kind_in;
   logic [ACC_W-1:0] opa_ff, opa_in;
   logic [ACC_W-1:0] opb_ff, opb_in;
   logic [ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0] res_ff, res_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [ACC_W:0]   trial;
   logic [ACC_W:0]   diff;
   logic             ge;
   logic [ACC_W-1:0] mul_sum;

   // One multiply or divide step
   always_comb begin
      trial   = {rem_ff, opb_ff[ACC_W-1]};
      diff    = trial - {1'b0, opa_ff};
      ge      = trial >= {1'b0, opa_ff};
      mul_sum = res_ff + (opb_ff[0] ? opa_ff : '0);
   end

   always_comb begin
      kind_in = kind_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (busy_ff) begin
         // Advance the iteration
         cnt_in = cnt_ff - 1'b1;
         if (kind_ff == UK_MUL) begin
            res_in = mul_sum;
            opa_in = {opa_ff[ACC_W-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[ACC_W-1:1]};
         end else begin
            rem_in = ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            opb_in = {opb_ff[ACC_W-2:0], ge};
            res_in = {opb_ff[ACC_W-2:0], ge};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         // Load the operands or finish at once
         kind_in = req.kind;
         cnt_in  = CNT_W'(ACC_W - 1);
         unique case (req.kind)
            UK_MUL: begin
               opa_in  = op_a;
               opb_in  = op_b;
               res_in  = '0;
               busy_in = 1'b1;
            end
            UK_DIV: begin
               opa_in  = op_b;
               opb_in  = op_a;
               rem_in  = '0;
               busy_in = 1'b1;
            end
            UK_ADD: begin
               res_in  = op_a + op_b;
               done_in = 1'b1;
            end
            UK_SUB: begin
               res_in  = op_a - op_b;
               done_in = 1'b1;
            end
            UK_AND: begin
               res_in  = op_a & op_b;
               done_in = 1'b1;
            end
            UK_OR: begin
               res_in  = op_a | op_b;
               done_in = 1'b1;
            end
            default: begin
               res_in  = ~op_a;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = res_ff;

endmodule
